// ----- rtl/core/tccw_pkg.sv -----
// Shared constants, types and helpers of the text console character writer.
`default_nettype none

package tccw_pkg;

    localparam int COLS       = 80;
    localparam int ROWS       = 25;
    localparam int TAB_STOP   = 8;
    localparam int CELL_COUNT = ROWS * COLS;
    localparam int COPY_COUNT = (ROWS - 1) * COLS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [7:0]        CHAR_TAB   = 8'd9;
    localparam logic [7:0]        CHAR_LF    = 8'd10;
    localparam logic [7:0]        CHAR_CR    = 8'd13;
    localparam logic [7:0]        CHAR_BLANK = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic {
        REG_FG = 1'b0,
        REG_BG = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        char_code;
        logic [ADDR_W-1:0] cell_index;
    } in_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } out_t;

    typedef struct packed {
        logic       put;
        logic       clear;
        logic [7:0] char_code;
    } cur_cmd_t;

    typedef struct packed {
        logic              write_en;
        logic [ADDR_W-1:0] write_addr;
        logic              scroll;
    } cur_step_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [CELL_W-1:0] make_cell(input logic [3:0] fg,
                                                    input logic [3:0] bg,
                                                    input logic [7:0] ch);
        return {bg, fg, ch};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tccw_screen_ram.sv -----
// Screen store: one write port and one registered read port.
`default_nettype none

module tccw_screen_ram (
    input  wire logic                      clk,
    input  wire tccw_pkg::mem_req_t        mem_req,
    output logic [tccw_pkg::CELL_W-1:0]    rdata
);
    import tccw_pkg::*;

    logic [CELL_W-1:0] mem [CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata <= mem[mem_req.raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tccw_cfg_regs.sv -----
// Color registers behind the APB-style configuration port.
`default_nettype none

module tccw_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tccw_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tccw_pkg::PDATA_W-1:0] pwdata,
    output logic      [tccw_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output logic      [3:0]                   fg,
    output logic      [3:0]                   bg
);
    import tccw_pkg::*;

    logic [3:0] fg_reg;
    logic [3:0] bg_reg;
    logic [3:0] fg_next;
    logic [3:0] bg_next;
    logic       wr_en;
    reg_idx_t   idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        prdata  = '0;
        unique case (idx)
            REG_FG:
            begin
                prdata = PDATA_W'(fg_reg);
                if (wr_en)
                begin
                    fg_next = pwdata[3:0];
                end
            end
            REG_BG:
            begin
                prdata = PDATA_W'(bg_reg);
                if (wr_en)
                begin
                    bg_next = pwdata[3:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= 4'hF;
            bg_reg <= 4'h0;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    assign fg = fg_reg;
    assign bg = bg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tccw_cursor.sv -----
// Cursor registers, their reset on clear, and the control-character and wrap decisions of put mode.
`default_nettype none

module tccw_cursor (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tccw_pkg::cur_cmd_t          cmd,
    output tccw_pkg::cur_step_t              step,
    output logic [tccw_pkg::ROW_W-1:0]       row,
    output logic [tccw_pkg::COL_W-1:0]       col
);
    import tccw_pkg::*;

    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  nl_row;
    logic              nl_scroll;
    logic [COL_W:0]    tab_col;
    logic [COL_W:0]    inc_col;
    logic [COL_W-1:0]  tab_rem;

    assign tab_rem = COL_W'(col_reg % TAB_STOP);
    assign tab_col = {1'b0, col_reg} + (COL_W + 1)'(TAB_STOP) - {1'b0, tab_rem};
    assign inc_col = {1'b0, col_reg} + (COL_W + 1)'(1);

    always_comb
    begin
        if (row_reg == ROW_W'(ROWS - 1))
        begin
            nl_row    = row_reg;
            nl_scroll = 1'b1;
        end
        else
        begin
            nl_row    = row_reg + ROW_W'(1);
            nl_scroll = 1'b0;
        end
    end

    always_comb
    begin
        step.write_en   = 1'b0;
        step.write_addr = ADDR_W'(row_reg) * ADDR_W'(COLS) + ADDR_W'(col_reg);
        step.scroll     = 1'b0;
        put_row         = row_reg;
        put_col         = col_reg;
        unique case (cmd.char_code)
            CHAR_LF:
            begin
                put_row     = nl_row;
                put_col     = '0;
                step.scroll = nl_scroll;
            end
            CHAR_CR:
            begin
                put_col = '0;
            end
            CHAR_TAB:
            begin
                if (tab_col >= (COL_W + 1)'(COLS))
                begin
                    put_row     = nl_row;
                    put_col     = '0;
                    step.scroll = nl_scroll;
                end
                else
                begin
                    put_col = tab_col[COL_W-1:0];
                end
            end
            default:
            begin
                step.write_en = 1'b1;
                if (inc_col >= (COL_W + 1)'(COLS))
                begin
                    put_row     = nl_row;
                    put_col     = '0;
                    step.scroll = nl_scroll;
                end
                else
                begin
                    put_col = inc_col[COL_W-1:0];
                end
            end
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.clear)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (cmd.put)
        begin
            row_next = put_row;
            col_next = put_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    assign row = row_reg;
    assign col = col_reg;

endmodule

`default_nettype wire

// ----- rtl/core/tccw_seq.sv -----
// Sequencer: item intake, store walks for scroll, clear and reset, and the result register.
`default_nettype none

module tccw_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire tccw_pkg::in_t               req_data,
    output logic                             req_stall,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output tccw_pkg::out_t                   rsp_data,
    input  wire logic [3:0]                  fg,
    input  wire logic [3:0]                  bg,
    output tccw_pkg::cur_cmd_t               cmd,
    input  wire tccw_pkg::cur_step_t         step,
    input  wire logic [tccw_pkg::ROW_W-1:0]  row,
    input  wire logic [tccw_pkg::COL_W-1:0]  col,
    output tccw_pkg::mem_req_t               mem_req,
    input  wire logic [tccw_pkg::CELL_W-1:0] rdata
);
    import tccw_pkg::*;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [ADDR_W-1:0] pend_addr_next;
    logic [CELL_W-1:0] fill_reg;
    logic [CELL_W-1:0] fill_next;
    logic              rd_sel_reg;
    logic              rd_sel_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_reg;
    out_t              out_next;
    logic              accept;
    logic [CELL_W-1:0] blank;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign blank     = make_cell(fg, bg, CHAR_BLANK);

    always_comb
    begin
        cmd.put       = accept && (req_data.mode == MODE_PUT);
        cmd.clear     = accept && (req_data.mode == MODE_CLEAR);
        cmd.char_code = req_data.char_code;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        fill_next      = fill_reg;
        rd_sel_next    = rd_sel_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        mem_req.we     = pend_reg;
        mem_req.waddr  = pend_addr_reg;
        mem_req.wdata  = rdata;
        mem_req.re     = 1'b0;
        mem_req.raddr  = req_data.cell_index;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                mem_req.wdata = RESET_CELL;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_sel_next = 1'b0;
                    cnt_next    = '0;
                    fill_next   = blank;
                    state_next  = ST_FINISH;
                    case (req_data.mode)
                        MODE_PUT:
                        begin
                            mem_req.we    = step.write_en;
                            mem_req.waddr = step.write_addr;
                            mem_req.wdata = make_cell(fg, bg, req_data.char_code);
                            if (step.scroll)
                            begin
                                state_next = ST_COPY;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            state_next = ST_FILL;
                        end
                        MODE_READ:
                        begin
                            if (req_data.cell_index < ADDR_W'(CELL_COUNT))
                            begin
                                mem_req.re  = 1'b1;
                                rd_sel_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                mem_req.re     = 1'b1;
                mem_req.raddr  = cnt_reg + ADDR_W'(COLS);
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                cnt_next       = cnt_reg + ADDR_W'(1);
                if (cnt_reg == ADDR_W'(COPY_COUNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cnt_reg;
                mem_req.wdata = fill_reg;
                if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next.cell_value = rd_sel_reg ? rdata : '0;
                    out_next.cursor_row = row;
                    out_next.cursor_col = col;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            rd_sel_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            rd_sel_reg    <= rd_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        fill_reg      <= fill_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/text_console_character_writer.sv -----
// A put, read or no-operation item goes to the finish state, which registers its result
// once the output is not stalled; no new item is taken until that result is registered.
// A put that scrolls walks the screen store through its one read port and one write port:
// copy 1920 cells up a row, drain, blank the last 80. A clear blanks all 2000 cells.
// After reset a clearing pass fills all 2000 cells with white-on-black spaces;
// req_stall stays high during it while configuration writes are still taken.
`default_nettype none

module text_console_character_writer (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tccw_pkg::PADDR_W-1:0] paddr,
    input  wire logic [tccw_pkg::PDATA_W-1:0] pwdata,
    output logic      [tccw_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire tccw_pkg::in_t                req_data,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output tccw_pkg::out_t                    rsp_data
);
    import tccw_pkg::*;

    logic [3:0]        fg;
    logic [3:0]        bg;
    cur_cmd_t          cmd;
    cur_step_t         step;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    mem_req_t          mem_req;
    logic [CELL_W-1:0] rdata;

    tccw_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .fg      (fg),
        .bg      (bg)
    );

    tccw_cursor u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .step  (step),
        .row   (row),
        .col   (col)
    );

    tccw_screen_ram u_screen_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    tccw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .fg        (fg),
        .bg        (bg),
        .cmd       (cmd),
        .step      (step),
        .row       (row),
        .col       (col),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/tccw_checker.sv -----
// Port-level checks of the text console character writer and their binding.
`default_nettype none

module tccw_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    input  wire logic           req_stall,
    input  wire logic           rsp_valid,
    input  wire logic           rsp_stall,
    input  wire tccw_pkg::out_t rsp_data
);
    import tccw_pkg::*;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("Input taken again before the previous result was produced.");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_data.cursor_row < ROW_W'(ROWS)) &&
                      (rsp_data.cursor_col < COL_W'(COLS)))
        else $error("Reported cursor lies outside the screen.");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("Stalled result changed or was dropped.");

    a_one_result_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("Result appeared while the block was idle.");

endmodule

bind text_console_character_writer tccw_checker u_checker (.*);

`default_nettype wire
